FILE: src/akst_pkg.sv
// Shared constants and command codes for the address-keyed slot table.
// Used by the table top level and its port checker; the storage RAM is generic and does not import it.
`timescale 1ns / 1ps

package akst_pkg;

	// Table geometry.
	localparam int SLOTS = 64;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	// Field widths of the command and result words.
	localparam int CMD_W   = 2;
	localparam int KEY_W   = 64;
	localparam int REF_W   = 64;
	localparam int SIZE_W  = 8;
	localparam int TITLE_W = 64;
	localparam int SLOT_W  = 6;
	localparam int VCNT_W  = 7;

	// Largest count the result can show.
	localparam int VCNT_MAX = (1 << VCNT_W) - 1;

	// One stored entry: key, data reference, size, title.
	localparam int ENTRY_W = KEY_W + REF_W + SIZE_W + TITLE_W;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

endpackage

FILE: src/akst_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; holds the stored entries of the slot table.
`timescale 1ns / 1ps

module akst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/address_keyed_slot_table.sv
// Add and remove scan the stored keys one slot a cycle through the entry RAM read port:
// the scan stops at a matching key or at the last slot, and the result word is then registered.
// Clear, commands with address zero and the unused code answer in the next cycle.
// One command at a time: busy stays high until the result strobe; the receiver cannot stall.
// Reset empties every slot at once through the valid flops; the RAM needs no clearing pass.
`timescale 1ns / 1ps

module address_keyed_slot_table
	import akst_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [CMD_W-1:0]   command,
	input  logic [KEY_W-1:0]   address,
	input  logic [REF_W-1:0]   value_ref,
	input  logic [SIZE_W-1:0]  value_size,
	input  logic [TITLE_W-1:0] title_id,
	output logic               done,
	output logic [SLOT_W-1:0]  slot,
	output logic               ok,
	output logic [VCNT_W-1:0]  valid_count
);

	typedef enum logic {ST_IDLE, ST_SCAN} state_t;

	state_t             state_q;
	logic [CMD_W-1:0]   cmd_q;
	logic [KEY_W-1:0]   key_q;
	logic [REF_W-1:0]   ref_q;
	logic [SIZE_W-1:0]  size_q;
	logic [TITLE_W-1:0] title_q;
	logic [SLOTS-1:0]   valid_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   idx_q;
	logic               issuing_q;
	logic [IDX_W-1:0]   idx_s1;
	logic               vld_s1;
	logic               have_empty_q;
	logic [IDX_W-1:0]   empty_idx_q;
	logic               done_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               ok_q;
	logic [VCNT_W-1:0]  vcnt_q;

	logic               accept;
	logic [ENTRY_W-1:0] rd_entry;
	logic [KEY_W-1:0]   rd_key;
	logic               cmp_valid;
	logic               hit;
	logic               last;
	logic               finish;
	logic               empty_here;
	logic [IDX_W-1:0]   add_slot;
	logic               add_ok;
	logic               ram_we;
	logic [CNT_W-1:0]   count_nx;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// Compare stage: the word read last cycle against the key being looked up.
	assign rd_key     = rd_entry[ENTRY_W-1 -: KEY_W];
	assign cmp_valid  = valid_q[idx_s1];
	assign hit        = vld_s1 && cmp_valid && (rd_key == key_q);
	assign last       = vld_s1 && (idx_s1 == IDX_W'(SLOTS - 1));
	assign finish     = (state_q == ST_SCAN) && (hit || last);
	assign empty_here = vld_s1 && !cmp_valid;

	// An add takes the matching slot, else the lowest empty slot seen in the scan.
	always_comb begin
		if (hit) begin
			add_slot = idx_s1;
		end else if (have_empty_q) begin
			add_slot = empty_idx_q;
		end else begin
			add_slot = idx_s1;
		end
	end
	assign add_ok = hit || have_empty_q || empty_here;
	assign ram_we = finish && (cmd_q == CMD_ADD) && add_ok;

	// Entry storage: key and payload words, one per slot.
	akst_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(add_slot),
		.wdata({key_q, ref_q, size_q, title_q}),
		.re   (issuing_q),
		.raddr(idx_q),
		.rdata(rd_entry)
	);

	// Count of valid slots once the finishing scan has been applied.
	always_comb begin
		count_nx = count_q;
		if (cmd_q == CMD_ADD && add_ok && !hit) begin
			count_nx = count_q + CNT_W'(1);
		end else if (cmd_q == CMD_REMOVE && hit) begin
			count_nx = count_q - CNT_W'(1);
		end
	end

	// Command sequencer, scan pointers, valid bits and registered result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			count_q      <= '0;
			issuing_q    <= 1'b0;
			vld_s1       <= 1'b0;
			have_empty_q <= 1'b0;
			done_q       <= 1'b0;
			vcnt_q       <= '0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= issuing_q;
			if (issuing_q) begin
				idx_s1 <= idx_q;
				idx_q  <= idx_q + IDX_W'(1);
				if (idx_q == IDX_W'(SLOTS - 1)) begin
					issuing_q <= 1'b0;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q   <= command;
						key_q   <= address;
						ref_q   <= value_ref;
						size_q  <= value_size;
						title_q <= title_id;
						slot_q  <= '0;
						if ((command == CMD_ADD || command == CMD_REMOVE) &&
								address != '0) begin
							state_q      <= ST_SCAN;
							idx_q        <= '0;
							issuing_q    <= 1'b1;
							have_empty_q <= 1'b0;
						end else begin
							// Answered at once: clear, address zero, unused code.
							done_q <= 1'b1;
							if (command == CMD_CLEAR) begin
								ok_q    <= (count_q != '0);
								valid_q <= '0;
								count_q <= '0;
								vcnt_q  <= '0;
							end else begin
								ok_q   <= 1'b0;
								vcnt_q <= (32'(count_q) > VCNT_MAX) ? VCNT_W'(VCNT_MAX)
									: VCNT_W'(count_q);
							end
						end
					end
				end
				ST_SCAN: begin
					if (empty_here && !have_empty_q) begin
						have_empty_q <= 1'b1;
						empty_idx_q  <= idx_s1;
					end
					if (finish) begin
						state_q   <= ST_IDLE;
						issuing_q <= 1'b0;
						vld_s1    <= 1'b0;
						done_q    <= 1'b1;
						count_q   <= count_nx;
						vcnt_q    <= (32'(count_nx) > VCNT_MAX) ? VCNT_W'(VCNT_MAX)
							: VCNT_W'(count_nx);
						if (cmd_q == CMD_ADD) begin
							ok_q   <= add_ok;
							slot_q <= add_ok ? SLOT_W'(add_slot) : '0;
							if (add_ok) begin
								valid_q[add_slot] <= 1'b1;
							end
						end else begin
							ok_q   <= hit;
							slot_q <= hit ? SLOT_W'(idx_s1) : '0;
							if (hit) begin
								valid_q[idx_s1] <= 1'b0;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign slot        = slot_q;
	assign ok          = ok_q;
	assign valid_count = vcnt_q;

endmodule

FILE: src/akst_checker.sv
// Port-level checks for the address-keyed slot table, and the bind that attaches them.
// Depends on akst_pkg and on the address_keyed_slot_table ports.
`timescale 1ns / 1ps

module akst_checker
	import akst_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [SLOT_W-1:0] slot,
	input logic              ok,
	input logic [VCNT_W-1:0] valid_count
);

	// A taken command is either still being worked on or answered next cycle.
	a_taken_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("taken command neither busy nor answered");

	// The end of a scan always delivers its result word.
	a_scan_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("scan ended without a result word");

	// A failed command reports slot zero.
	a_fail_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> (slot == '0))
		else $error("failed command reports a nonzero slot");

	// The count moves only with a result word and never exceeds the table size.
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> $stable(valid_count))
		else $error("valid count changed without a result word");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(valid_count) <= SLOTS)
		else $error("valid count exceeds the table size");

endmodule

bind address_keyed_slot_table akst_checker u_akst_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.slot       (slot),
	.ok         (ok),
	.valid_count(valid_count)
);
